FILE: rtl/sst_pkg.sv
// ---------------------------------------------------------------------------
// sst_pkg
// Shared types and codes of the score sorted table: operation and status
// codes and the fixed widths of the item fields.
// ---------------------------------------------------------------------------
package sst_pkg;

    // Fixed field widths
    localparam int ID_BITS       = 63;
    localparam int IN_SCORE_BITS = 32;
    localparam int RANK_BITS     = 6;
    localparam int COUNT_BITS    = 7;
    localparam int STATUS_BITS   = 3;

    typedef logic [1:0]               t_op;
    typedef logic [STATUS_BITS-1:0]   t_status;
    typedef logic [ID_BITS-1:0]       t_id;
    typedef logic [IN_SCORE_BITS-1:0] t_score_in;
    typedef logic [RANK_BITS-1:0]     t_rank;
    typedef logic [COUNT_BITS-1:0]    t_count;

    // Operation codes
    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_REMOVE = 2'd1;
    localparam t_op OP_READ   = 2'd2;
    localparam t_op OP_CLEAR  = 2'd3;

    // Status codes
    localparam t_status ST_OK         = 3'd0;
    localparam t_status ST_DROPPED    = 3'd1;
    localparam t_status ST_REJECTED   = 3'd2;
    localparam t_status ST_NOT_FOUND  = 3'd3;
    localparam t_status ST_RANK_EMPTY = 3'd4;

endpackage

FILE: rtl/sst_ram.sv
// ---------------------------------------------------------------------------
// sst_ram
// Generic single-clock RAM, one write port and one read port with the
// read data registered.
// ---------------------------------------------------------------------------
module sst_ram #(
    parameter int WIDTH = 95,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/score_sorted_table.sv
// ---------------------------------------------------------------------------
// score_sorted_table
// Table of (id, score) entries in descending score order, held in one RAM
// and updated by a sequencer that walks it one entry per cycle.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears
// for exactly one cycle with o_valid high and cannot be held off, and busy
// is low in that same cycle. Clear and any op that needs no table access
// (remove on an empty table, read beyond the count) are answered from idle;
// read waits for the registered RAM data; insert walks up from the bottom,
// moving each lower-scored entry down as it goes, and a rejected insert on
// a full table stops at the bottom entry; remove searches from the top,
// then closes the gap. The longest items walk the whole table, as the entry
// RAM has a single read and a single write port.
// ---------------------------------------------------------------------------
module score_sorted_table #(
    parameter int CAPACITY   = 64,
    parameter int SCORE_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  sst_pkg::t_op        i_op,
    input  sst_pkg::t_id        i_account_id,
    input  sst_pkg::t_score_in  i_new_score,
    input  sst_pkg::t_rank      i_read_rank,
    output logic                o_valid,
    output sst_pkg::t_status    o_status,
    output sst_pkg::t_rank      o_rank,
    output sst_pkg::t_id        o_entry_id,
    output sst_pkg::t_score_in  o_entry_score,
    output sst_pkg::t_count     o_entry_count
);

    import sst_pkg::*;

    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int EW       = ID_BITS + SCORE_BITS;
    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    // Sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS_CMP  = 3'd1;
    localparam logic [2:0] S_INS_PUT  = 3'd2;
    localparam logic [2:0] S_RM_FIND  = 3'd3;
    localparam logic [2:0] S_RM_SHIFT = 3'd4;
    localparam logic [2:0] S_RD_WAIT  = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_idx, n_idx;
    logic [AW-1:0]         r_pos, n_pos;
    logic                  r_full, n_full;
    t_id                   r_id, n_id;
    logic [SCORE_BITS-1:0] r_score, n_score;

    logic                  r_valid, n_valid;
    t_status               r_status, n_status;
    t_rank                 r_rank, n_rank;
    t_id                   r_eid, n_eid;
    t_score_in             r_escore, n_escore;
    t_count                r_ecount, n_ecount;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [EW-1:0]         ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [EW-1:0]         ram_rdata;

    t_id                   rd_id;
    logic [SCORE_BITS-1:0] rd_score;
    logic [AW-1:0]         last_idx;
    logic [CW-1:0]         count_dec;

    // Entry store: {id, score} per rank
    sst_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_id     = ram_rdata[EW-1:SCORE_BITS];
    assign rd_score  = ram_rdata[SCORE_BITS-1:0];
    assign last_idx  = AW'(r_count - CW'(1));
    assign count_dec = r_count - CW'(1);

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_full    = r_full;
        n_id      = r_id;
        n_score   = r_score;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_rank    = r_rank;
        n_eid     = '0;
        n_escore  = '0;
        n_ecount  = r_ecount;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = ram_rdata;
        ram_raddr = r_idx;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_id     = i_account_id;
                    n_score  = SCORE_BITS'(i_new_score);
                    n_full   = (r_count == FULL_CNT);
                    n_ecount = COUNT_BITS'(r_count);
                    case (i_op)
                        OP_INSERT: begin
                            if (r_count == '0) begin
                                n_pos   = '0;
                                n_state = S_INS_PUT;
                            end else begin
                                ram_raddr = last_idx;
                                n_idx     = last_idx;
                                n_state   = S_INS_CMP;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_count == '0) begin
                                n_valid  = 1'b1;
                                n_status = ST_NOT_FOUND;
                                n_rank   = '0;
                            end else begin
                                ram_raddr = '0;
                                n_idx     = '0;
                                n_state   = S_RM_FIND;
                            end
                        end
                        OP_READ: begin
                            if (32'(i_read_rank) < 32'(r_count)) begin
                                ram_raddr = AW'(i_read_rank);
                                n_pos     = AW'(i_read_rank);
                                n_state   = S_RD_WAIT;
                            end else begin
                                n_valid  = 1'b1;
                                n_status = ST_RANK_EMPTY;
                                n_rank   = i_read_rank;
                            end
                        end
                        default: begin
                            // clear
                            n_count  = '0;
                            n_valid  = 1'b1;
                            n_status = ST_OK;
                            n_rank   = '0;
                            n_ecount = '0;
                        end
                    endcase
                end
            end

            // Walk up from the bottom; lower scores move down one slot
            S_INS_CMP: begin
                if (rd_score < r_score) begin
                    if (r_idx != LAST_IDX) begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(r_idx + 1'b1);
                    end
                    if (r_idx == '0) begin
                        n_pos   = '0;
                        n_state = S_INS_PUT;
                    end else begin
                        ram_raddr = AW'(r_idx - 1'b1);
                        n_idx     = AW'(r_idx - 1'b1);
                    end
                end else if (r_full && r_idx == LAST_IDX) begin
                    // full and not above the lowest score
                    n_valid  = 1'b1;
                    n_status = ST_REJECTED;
                    n_rank   = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_pos   = AW'(r_idx + 1'b1);
                    n_state = S_INS_PUT;
                end
            end

            // Place the new entry
            S_INS_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos;
                ram_wdata = {r_id, r_score};
                if (!r_full) begin
                    n_count = r_count + CW'(1);
                end
                n_valid  = 1'b1;
                n_status = r_full ? ST_DROPPED : ST_OK;
                n_rank   = RANK_BITS'(r_pos);
                n_ecount = COUNT_BITS'(r_full ? r_count : r_count + CW'(1));
                n_state  = S_IDLE;
            end

            // Search from the top for the first matching id
            S_RM_FIND: begin
                if (rd_id == r_id) begin
                    n_pos = r_idx;
                    if (r_idx == last_idx) begin
                        n_count  = count_dec;
                        n_valid  = 1'b1;
                        n_status = ST_OK;
                        n_rank   = RANK_BITS'(r_idx);
                        n_ecount = COUNT_BITS'(count_dec);
                        n_state  = S_IDLE;
                    end else begin
                        ram_raddr = AW'(r_idx + 1'b1);
                        n_idx     = AW'(r_idx + 1'b1);
                        n_state   = S_RM_SHIFT;
                    end
                end else if (r_idx == last_idx) begin
                    n_valid  = 1'b1;
                    n_status = ST_NOT_FOUND;
                    n_rank   = '0;
                    n_state  = S_IDLE;
                end else begin
                    ram_raddr = AW'(r_idx + 1'b1);
                    n_idx     = AW'(r_idx + 1'b1);
                end
            end

            // Close the gap: each later entry moves up one slot
            S_RM_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_idx - 1'b1);
                if (r_idx == last_idx) begin
                    n_count  = count_dec;
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_rank   = RANK_BITS'(r_pos);
                    n_ecount = COUNT_BITS'(count_dec);
                    n_state  = S_IDLE;
                end else begin
                    ram_raddr = AW'(r_idx + 1'b1);
                    n_idx     = AW'(r_idx + 1'b1);
                end
            end

            S_RD_WAIT: begin
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_rank   = RANK_BITS'(r_pos);
                n_eid    = rd_id;
                n_escore = IN_SCORE_BITS'(rd_score);
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // Working and result payload
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_full   <= n_full;
        r_id     <= n_id;
        r_score  <= n_score;
        r_status <= n_status;
        r_rank   <= n_rank;
        r_eid    <= n_eid;
        r_escore <= n_escore;
        r_ecount <= n_ecount;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_rank        = r_rank;
    assign o_entry_id    = r_eid;
    assign o_entry_score = r_escore;
    assign o_entry_count = r_ecount;

endmodule

FILE: tb/score_sorted_table_checker.sv
// ---------------------------------------------------------------------------
// score_sorted_table_checker
// Watches the command and result ports of the score sorted table. It keeps
// its own copy of the table, works out the result of every accepted item and
// compares each result strobe against the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module score_sorted_table_checker #(
    parameter int CAPACITY   = 64,
    parameter int SCORE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  sst_pkg::t_op       i_op,
    input  sst_pkg::t_id       i_account_id,
    input  sst_pkg::t_score_in i_new_score,
    input  sst_pkg::t_rank     i_read_rank,
    input  logic               i_valid,
    input  sst_pkg::t_status   i_status,
    input  sst_pkg::t_rank     i_rank,
    input  sst_pkg::t_id       i_entry_id,
    input  sst_pkg::t_score_in i_entry_score,
    input  sst_pkg::t_count    i_entry_count,
    output int                 o_mismatches,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_full_events
);

    import sst_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef logic [SCORE_BITS-1:0] t_key;

    typedef struct packed {
        t_status   status;
        t_rank     rank;
        t_id       id;
        t_score_in score;
        t_count    count;
    } t_table_result;

    // Shadow table: ids and scores by rank, plus the number of valid entries
    t_id            shadow_id [CAPACITY];
    t_key           shadow_key[CAPACITY];
    int             shadow_fill;

    t_table_result  outcome_q[$];
    int             mismatches;
    int             pending;
    int             checked;
    int             full_events;

    assign o_mismatches  = mismatches;
    assign o_pending     = pending;
    assign o_checked     = checked;
    assign o_full_events = full_events;

    // Apply one item to the shadow table and return the result it produces
    task automatic apply_table_op(input t_op op, input t_id id, input t_score_in sc,
                                  input t_rank rr, output t_table_result res);
        t_key key;
        int   n;
        int   pos;
        bit   hit;
        key = t_key'(sc);
        n   = shadow_fill;
        pos = 0;
        hit = 1'b0;
        res = '0;
        res.status = ST_OK;
        case (op)
            OP_INSERT: begin
                // first entry with a strictly lower score; ties stay in order
                pos = n;
                for (int i = 0; i < n; i++) begin
                    if (!hit && key > shadow_key[i]) begin
                        pos = i;
                        hit = 1'b1;
                    end
                end
                if (n >= CAPACITY && pos >= n) begin
                    res.status = ST_REJECTED;
                end else begin
                    if (n >= CAPACITY) begin
                        // last entry falls off the bottom
                        res.status = ST_DROPPED;
                        n = CAPACITY - 1;
                    end
                    for (int i = n; i > pos; i--) begin
                        shadow_id[i]  = shadow_id[i-1];
                        shadow_key[i] = shadow_key[i-1];
                    end
                    shadow_id[pos]  = id;
                    shadow_key[pos] = key;
                    shadow_fill     = n + 1;
                    res.rank        = t_rank'(pos);
                end
            end
            OP_REMOVE: begin
                for (int i = 0; i < n; i++) begin
                    if (!hit && shadow_id[i] == id) begin
                        pos = i;
                        hit = 1'b1;
                    end
                end
                if (!hit) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    for (int i = pos; i + 1 < n; i++) begin
                        shadow_id[i]  = shadow_id[i+1];
                        shadow_key[i] = shadow_key[i+1];
                    end
                    shadow_fill = n - 1;
                    res.rank    = t_rank'(pos);
                end
            end
            OP_READ: begin
                res.rank = rr;
                if (int'(rr) < n) begin
                    res.id    = shadow_id[rr];
                    res.score = t_score_in'(shadow_key[rr]);
                end else begin
                    res.status = ST_RANK_EMPTY;
                end
            end
            default: begin
                shadow_fill = 0;
            end
        endcase
        res.count = t_count'(shadow_fill);
    endtask

    // Check the result strobe first, then predict the item taken at this edge
    always @(posedge i_clk) begin : watch_ports
        t_table_result got;
        t_table_result want;
        if (!i_rst_n) begin
            shadow_fill = 0;
            outcome_q.delete();
            pending     = 0;
            mismatches  = 0;
            checked     = 0;
            full_events = 0;
        end else begin
            if (i_valid) begin
                got = '{i_status, i_rank, i_entry_id, i_entry_score, i_entry_count};
                if (outcome_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"[%0t] unexpected result: status %0d rank %0d",
                                  " id %h score %h count %0d"},
                                 $time, got.status, got.rank, got.id, got.score, got.count);
                end else begin
                    want = outcome_q.pop_front();
                    pending--;
                    checked++;
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display({"[%0t] mismatch: exp status %0d rank %0d",
                                      " id %h score %h count %0d"},
                                     $time, want.status, want.rank, want.id, want.score,
                                     want.count);
                            $display({"[%0t]           got status %0d rank %0d",
                                      " id %h score %h count %0d"},
                                     $time, got.status, got.rank, got.id, got.score,
                                     got.count);
                        end
                    end
                end
            end
            if (i_start && !i_busy) begin
                apply_table_op(i_op, i_account_id, i_new_score, i_read_rank, want);
                if (want.status == ST_DROPPED || want.status == ST_REJECTED)
                    full_events++;
                outcome_q.push_back(want);
                pending++;
            end
        end
    end

endmodule

FILE: tb/tb_score_sorted_table.sv
// ---------------------------------------------------------------------------
// tb_score_sorted_table
// Drives the score sorted table with a short directed sequence and then
// phases of random inserts, removes, reads and clears that fill the table,
// churn it and drain it. The checker beside the block predicts and compares
// every result; this module only makes stimulus and reports the verdict.
// ---------------------------------------------------------------------------
module tb_score_sorted_table;
    import sst_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int SCORE_BITS   = 32;
    localparam int RANDOM_ITEMS = 1200;
    localparam int POOL_SIZE    = 48;
    localparam int CYCLE_LIMIT  = 600000;
    // settling time after the last result, longer than the block's longest item
    localparam int DRAIN_CYCLES = CAPACITY + 8;

    typedef enum int {MIX_FILL, MIX_CHURN, MIX_READS, MIX_DRAIN} t_mix;

    logic      i_clk        = 1'b0;
    logic      i_rst_n      = 1'b0;
    logic      start        = 1'b0;
    t_op       i_op         = OP_CLEAR;
    t_id       i_account_id = '0;
    t_score_in i_new_score  = '0;
    t_rank     i_read_rank  = '0;
    logic      busy;
    logic      o_valid;
    t_status   o_status;
    t_rank     o_rank;
    t_id       o_entry_id;
    t_score_in o_entry_score;
    t_count    o_entry_count;

    int        mismatches;
    int        pending;
    int        checked;
    int        full_events;

    int        cycles       = 0;
    bit        idle_enable  = 1'b1;
    int        op_sent[4];
    t_id       id_pool[POOL_SIZE];

    always #6 i_clk = ~i_clk;

    score_sorted_table #(
        .CAPACITY   (CAPACITY),
        .SCORE_BITS (SCORE_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_account_id  (i_account_id),
        .i_new_score   (i_new_score),
        .i_read_rank   (i_read_rank),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_rank        (o_rank),
        .o_entry_id    (o_entry_id),
        .o_entry_score (o_entry_score),
        .o_entry_count (o_entry_count)
    );

    score_sorted_table_checker #(
        .CAPACITY   (CAPACITY),
        .SCORE_BITS (SCORE_BITS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_op          (i_op),
        .i_account_id  (i_account_id),
        .i_new_score   (i_new_score),
        .i_read_rank   (i_read_rank),
        .i_valid       (o_valid),
        .i_status      (o_status),
        .i_rank        (o_rank),
        .i_entry_id    (o_entry_id),
        .i_entry_score (o_entry_score),
        .i_entry_count (o_entry_count),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_full_events (full_events)
    );

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Present one item at a falling edge and hold it until it is taken
    task automatic issue(input t_op op, input t_id id, input t_score_in sc, input t_rank rr);
        if (idle_enable && $urandom_range(99) < 29) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        start        <= 1'b1;
        i_op         <= op;
        i_account_id <= id;
        i_new_score  <= sc;
        i_read_rank  <= rr;
        do @(posedge i_clk); while (busy);
        op_sent[op]++;
        @(negedge i_clk);
    endtask

    // Hold off new items until every predicted result has come back
    task automatic wait_drained();
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Mostly ids from a small pool so removes hit and duplicates occur
    function automatic t_id pick_id();
        if ($urandom_range(99) < 82)
            return id_pool[$urandom_range(POOL_SIZE - 1)];
        return t_id'({$urandom(), $urandom()});
    endfunction

    // One random item, with the op mix of the current phase
    task automatic issue_random(input t_mix mix);
        int        pick;
        int        lim_ins;
        int        lim_rem;
        int        lim_read;
        t_score_in sc;
        t_rank     rr;
        case (mix)
            MIX_FILL:  begin lim_ins = 80; lim_rem = 85; lim_read = 100; end
            MIX_CHURN: begin lim_ins = 45; lim_rem = 75; lim_read = 98;  end
            MIX_READS: begin lim_ins = 20; lim_rem = 30; lim_read = 100; end
            default:   begin lim_ins = 15; lim_rem = 75; lim_read = 100; end
        endcase
        // scores: extremes, small values and a tight high band to force ties
        pick = $urandom_range(99);
        if (pick < 10)
            sc = $urandom_range(1) ? '1 : '0;
        else if (pick < 35)
            sc = t_score_in'($urandom_range(15));
        else if (pick < 50)
            sc = 32'h8000_0000 + t_score_in'($urandom_range(3));
        else
            sc = t_score_in'($urandom());
        rr = $urandom_range(1) ? t_rank'($urandom_range(63)) : t_rank'($urandom_range(7));
        pick = $urandom_range(99);
        if (pick < lim_ins)
            issue(OP_INSERT, pick_id(), sc, rr);
        else if (pick < lim_rem)
            issue(OP_REMOVE, pick_id(), sc, rr);
        else if (pick < lim_read)
            issue(OP_READ, pick_id(), sc, rr);
        else
            issue(OP_CLEAR, pick_id(), sc, rr);
    endtask

    initial begin
        int   sent;
        int   phase;
        int   span;
        t_mix mix;
        t_id  id_a;
        t_id  id_b;
        sent  = 0;
        phase = 0;
        id_a  = 63'h2AAA_AAAA_AAAA_AAAA;
        id_b  = 63'h5555_5555_5555_5555;
        for (int i = 0; i < 4; i++) op_sent[i] = 0;
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = t_id'({$urandom(), $urandom()});

        // Reset
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table cases
        issue(OP_READ,   '0, '0, '0);
        issue(OP_REMOVE, '0, '0, '0);
        issue(OP_CLEAR,  '1, '1, '1);
        // extremes of id and score, equal scores keep arrival order
        issue(OP_INSERT, '1,   '1,     '0);
        issue(OP_INSERT, '0,   '0,     '0);
        issue(OP_INSERT, id_a, 32'd1000, '0);
        issue(OP_INSERT, id_b, 32'd1000, '0);
        issue(OP_INSERT, id_a, '1,     '0);
        for (int r = 0; r < 6; r++) issue(OP_READ, '0, '0, t_rank'(r));
        issue(OP_READ,   '0, '0, '1);
        // remove from the middle, an absent id, and the first of three matches
        issue(OP_REMOVE, id_b, '0, '0);
        issue(OP_REMOVE, t_id'(12345), '0, '0);
        issue(OP_INSERT, id_a, 32'd1000, '0);
        issue(OP_REMOVE, id_a, '0, '0);
        issue(OP_READ,   '0, '0, t_rank'(2));
        issue(OP_CLEAR,  '0, '0, '0);
        issue(OP_READ,   '0, '0, '0);
        wait_drained();

        // Random phases: fill to capacity, churn, read, drain, and repeat
        while (sent < RANDOM_ITEMS) begin
            mix         = t_mix'(phase % 4);
            span        = $urandom_range(150, 220);
            idle_enable = (phase != 2);
            for (int k = 0; k < span && sent < RANDOM_ITEMS; k++) begin
                issue_random(mix);
                sent++;
            end
            wait_drained();
            phase++;
        end
        idle_enable = 1'b1;

        // Let the block settle, then report
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Covered %0d inserts, %0d removes, %0d reads and %0d clears",
                 op_sent[OP_INSERT], op_sent[OP_REMOVE], op_sent[OP_READ], op_sent[OP_CLEAR]);
        $display("%0d results checked, %0d of them inserts against a full table",
                 checked, full_events);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
